@@ hdl/scfd_pkg.sv @@
// ----------------------------------------------------------------------------
// scfd_pkg
// Shared types and constants for the SATA command FIS decoder.
// ----------------------------------------------------------------------------
package scfd_pkg;

  // ATA opcodes that select the DMA variant on the general path
  localparam logic [7:0] OP_READ_DMA      = 8'hC8;
  localparam logic [7:0] OP_READ_DMA_EXT  = 8'h25;
  localparam logic [7:0] OP_WRITE_DMA     = 8'hCA;
  localparam logic [7:0] OP_WRITE_DMA_EXT = 8'h35;

  // Zero sector count defaults
  localparam logic [16:0] CNT28_DEFAULT = 17'h00100;
  localparam logic [16:0] CNT48_DEFAULT = 17'h10000;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPW_LOW     = 3'd0,
    CFG_SPW_HIGH    = 3'd1,
    CFG_SPR_LOW     = 3'd2,
    CFG_SPR_HIGH    = 3'd3,
    CFG_LAST_LBA    = 3'd4,
    CFG_CHS_HEADS   = 3'd5,
    CFG_CHS_SECTORS = 3'd6
  } scfd_cfg_e;

  localparam logic [4:0] CHS_HEADS_RST   = 5'd16;
  localparam logic [7:0] CHS_SECTORS_RST = 8'd63;

  typedef enum logic [2:0] {
    ACT_ID_NOT_FOUND = 3'd0,
    ACT_DMA_WRITE    = 3'd1,
    ACT_PIO_WRITE    = 3'd2,
    ACT_DMA_READ     = 3'd3,
    ACT_PIO_READ     = 3'd4,
    ACT_SLOW         = 3'd5
  } scfd_action_e;

  // Shared multiply-add unit: res = a * b + c
  localparam int unsigned MAC_A_W   = 24;
  localparam int unsigned MAC_B_W   = 25;
  localparam int unsigned MAC_C_W   = 32;
  localparam int unsigned MAC_RES_W = 50;

  typedef struct packed {
    logic [MAC_A_W-1:0] a;
    logic [MAC_B_W-1:0] b;
    logic [MAC_C_W-1:0] c;
  } scfd_mac_op_t;

  typedef struct packed {
    logic [7:0]  command_code;
    logic [31:0] fis_word1;
    logic [7:0]  fis_word2_low;
    logic [15:0] fis_word3_low;
    logic [31:0] file_id;
    logic        class_lba28;
    logic        class_lba48;
    logic        class_no_count;
    logic        class_host_to_device;
    logic        class_device_to_host;
    logic [5:0]  consumer_front;
    logic        hw_queue_full;
  } scfd_req_t;

  typedef struct packed {
    scfd_action_e action;
    logic         action_deferred;
    logic [31:0]  block_address;
    logic [16:0]  block_count;
    logic [25:0]  transfer_bytes;
    logic         entry_pushed;
    logic [5:0]   entry_slot;
    logic [31:0]  entry_address;
    logic [31:0]  entry_type_word;
    logic [31:0]  entry_file;
    logic [7:0]   pushed_count_low;
  } scfd_rsp_t;

endpackage

@@ hdl/sata_command_fis_decoder_core.sv @@
// ----------------------------------------------------------------------------
// sata_command_fis_decoder_core
// Host-to-device command decoder: address, count, limit check, action and
// event ring entry for one received command FIS.
// ----------------------------------------------------------------------------
// One command request is taken at a time; in_ready_o is low while it is
// decoded. A command passes through these steps: one to take it, two
// multiply-add steps for a CHS address, three steps for a special opcode
// (reciprocal multiply, back-multiply, correction), one step for the byte
// count and one to load the result register. The multiply-add steps share a
// single multiply-add unit. Loading waits as long as the result register still
// holds an untaken result. The result register holds a finished result until
// it is taken, and the next request may be taken meanwhile. Configuration
// writes are taken every cycle and must only be issued while no request is in
// flight. There is no clearing pass after reset.
module sata_command_fis_decoder_core #(
  parameter int RING_DEPTH   = 64,
  parameter int SECTOR_BYTES = 512
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  scfd_pkg::scfd_req_t               in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output scfd_pkg::scfd_rsp_t               out_rsp_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [scfd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]                       cfg_data_i
);
  import scfd_pkg::*;

  localparam int unsigned IDX_W  = $clog2(RING_DEPTH);
  localparam int unsigned CMP_W  = 9;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);
  // offset = word1[23:0] * 512, so offset / SECTOR_BYTES = a * 2^33 / SB / 2^24
  localparam logic [33:0] OFFSET_SPAN = 34'h2_0000_0000;
  localparam logic [MAC_B_W-1:0] RECIP  = MAC_B_W'(OFFSET_SPAN / SECTOR_BYTES);
  localparam logic [MAC_B_W-1:0] SB_B   = MAC_B_W'(SECTOR_BYTES);
  localparam logic [33:0]        SB_REM = 34'(SECTOR_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHS_A,
    ST_CHS_B,
    ST_DIV_A,
    ST_DIV_B,
    ST_DIV_C,
    ST_XFER,
    ST_DONE
  } state_e;

  state_e           state_q;
  scfd_req_t        req_q;
  logic             special_q, dma_wr_q, dma_rd_q;
  logic [31:0]      lba_q;
  logic [16:0]      count_q;
  logic [33:0]      mul_q;
  logic [23:0]      quot_q;
  logic [25:0]      xfer_q;
  logic [IDX_W-1:0] ring_idx_q;
  logic [7:0]       push_total_q;
  logic             out_valid_q;
  scfd_rsp_t        out_rsp_q;

  logic [7:0]  spw_low_q, spw_high_q, spr_low_q, spr_high_q;
  logic [31:0] last_lba_q;
  logic [4:0]  chs_heads_q;
  logic [7:0]  chs_sectors_q;

  // ---------------------------------------------------------------- accept
  logic        in_fire;
  logic        sp_wr, sp_rd, special;
  logic [31:0] lba_base;
  logic [16:0] count_base;
  logic        chs_mode;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    sp_wr    = (in_req_i.command_code > spw_low_q) && (in_req_i.command_code < spw_high_q);
    sp_rd    = (in_req_i.command_code > spr_low_q) && (in_req_i.command_code < spr_high_q);
    special  = sp_wr || sp_rd;
    chs_mode = in_req_i.class_lba28 && !in_req_i.fis_word1[30];
    lba_base   = '0;
    count_base = '0;
    if (in_req_i.class_lba28) begin
      lba_base   = {4'b0, in_req_i.fis_word1[27:0]};
      count_base = {9'b0, in_req_i.fis_word3_low[7:0]};
      if (count_base == '0 && !in_req_i.class_no_count) begin
        count_base = CNT28_DEFAULT;
      end
    end else if (in_req_i.class_lba48) begin
      lba_base   = {in_req_i.fis_word2_low, in_req_i.fis_word1[23:0]};
      count_base = {1'b0, in_req_i.fis_word3_low};
      if (count_base == '0 && !in_req_i.class_no_count) begin
        count_base = CNT48_DEFAULT;
      end
    end
  end

  // ------------------------------------------------------- shared unit ops
  scfd_mac_op_t           mac_op;
  logic [MAC_RES_W-1:0]   mac_res;

  always_comb begin
    mac_op = '0;
    case (state_q)
      ST_CHS_A: begin
        mac_op.a = MAC_A_W'(req_q.fis_word1[23:8]);
        mac_op.b = MAC_B_W'(chs_heads_q);
        mac_op.c = MAC_C_W'(req_q.fis_word1[27:24]);
      end
      ST_CHS_B: begin
        // sector minus one wraps modulo 2^32 when the sector is zero
        mac_op.a = mul_q[MAC_A_W-1:0];
        mac_op.b = MAC_B_W'(chs_sectors_q);
        mac_op.c = MAC_C_W'(req_q.fis_word1[7:0]) - MAC_C_W'(1);
      end
      ST_DIV_A: begin
        mac_op.a = req_q.fis_word1[23:0];
        mac_op.b = RECIP;
      end
      ST_DIV_B: begin
        mac_op.a = quot_q;
        mac_op.b = SB_B;
      end
      ST_XFER: begin
        mac_op.a = MAC_A_W'(count_q);
        mac_op.b = SB_B;
      end
      default: mac_op = '0;
    endcase
  end

  scfd_mac u_mac (
    .op_i  (mac_op),
    .res_o (mac_res)
  );

  // Remainder of the reciprocal estimate: below twice SECTOR_BYTES
  logic [33:0] div_rem;
  assign div_rem = {1'b0, req_q.fis_word1[23:0], 9'b0} - mul_q;

  // ---------------------------------------------------------------- decide
  logic [32:0]      range_end, range_limit;
  logic             limit_fail, fast, ring_full, push;
  logic [IDX_W-1:0] idx_next;
  logic [CMP_W-1:0] idx_ext;
  scfd_rsp_t        done_rsp;
  logic             out_free;

  always_comb begin
    range_end   = {1'b0, lba_q} + 33'(count_q);
    range_limit = {1'b0, last_lba_q} + 33'd1;
    limit_fail  = !req_q.class_no_count && (range_end > range_limit);
    fast        = req_q.class_host_to_device || req_q.class_device_to_host;
    idx_next    = (ring_idx_q == IDX_LAST) ? '0 : ring_idx_q + 1'b1;
    // a consumer index at or beyond the depth never matches
    ring_full   = (CMP_W'(idx_next) == CMP_W'(req_q.consumer_front));
    push        = !limit_fail && fast && !ring_full;
    idx_ext     = CMP_W'(ring_idx_q);

    done_rsp = '0;
    if (limit_fail) begin
      done_rsp.action = ACT_ID_NOT_FOUND;
    end else if (fast) begin
      if (req_q.class_host_to_device) begin
        done_rsp.action = dma_wr_q ? ACT_DMA_WRITE : ACT_PIO_WRITE;
      end else begin
        done_rsp.action = dma_rd_q ? ACT_DMA_READ : ACT_PIO_READ;
      end
      done_rsp.action_deferred = req_q.hw_queue_full;
      done_rsp.transfer_bytes  = xfer_q;
    end else begin
      done_rsp.action = ACT_SLOW;
    end
    done_rsp.block_address = lba_q;
    done_rsp.block_count   = count_q;
    if (push) begin
      done_rsp.entry_pushed = 1'b1;
      done_rsp.entry_slot   = idx_ext[5:0];
      if (special_q) begin
        done_rsp.entry_address   = {req_q.fis_word1[22:0], 9'b0};
        done_rsp.entry_type_word = {7'b0, req_q.class_host_to_device, 15'b0,
                                    req_q.fis_word1[23], req_q.command_code};
        done_rsp.entry_file      = req_q.file_id;
      end else begin
        done_rsp.entry_address   = lba_q;
        done_rsp.entry_type_word = {31'b0, req_q.class_host_to_device};
      end
    end
    done_rsp.pushed_count_low = push ? push_total_q + 8'd1 : push_total_q;
    out_free = !out_valid_q || out_ready_i;
  end

  // ------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      req_q         <= '0;
      special_q     <= 1'b0;
      dma_wr_q      <= 1'b0;
      dma_rd_q      <= 1'b0;
      lba_q         <= '0;
      count_q       <= '0;
      mul_q         <= '0;
      quot_q        <= '0;
      xfer_q        <= '0;
      ring_idx_q    <= '0;
      push_total_q  <= '0;
      out_valid_q   <= 1'b0;
      out_rsp_q     <= '0;
      spw_low_q     <= '0;
      spw_high_q    <= '0;
      spr_low_q     <= '0;
      spr_high_q    <= '0;
      last_lba_q    <= '0;
      chs_heads_q   <= CHS_HEADS_RST;
      chs_sectors_q <= CHS_SECTORS_RST;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SPW_LOW:     spw_low_q     <= cfg_data_i[7:0];
          CFG_SPW_HIGH:    spw_high_q    <= cfg_data_i[7:0];
          CFG_SPR_LOW:     spr_low_q     <= cfg_data_i[7:0];
          CFG_SPR_HIGH:    spr_high_q    <= cfg_data_i[7:0];
          CFG_LAST_LBA:    last_lba_q    <= cfg_data_i;
          CFG_CHS_HEADS:   chs_heads_q   <= cfg_data_i[4:0];
          CFG_CHS_SECTORS: chs_sectors_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end

      // the done state reloads the result register itself
      if (out_valid_q && out_ready_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            req_q     <= in_req_i;
            special_q <= special;
            dma_wr_q  <= sp_wr || in_req_i.command_code == OP_WRITE_DMA
                               || in_req_i.command_code == OP_WRITE_DMA_EXT;
            dma_rd_q  <= sp_rd || in_req_i.command_code == OP_READ_DMA
                               || in_req_i.command_code == OP_READ_DMA_EXT;
            lba_q     <= lba_base;
            count_q   <= count_base;
            // the special address replaces any CHS result, so skip CHS then
            if (special) begin
              state_q <= ST_DIV_A;
            end else if (chs_mode) begin
              state_q <= ST_CHS_A;
            end else begin
              state_q <= ST_XFER;
            end
          end
        end
        ST_CHS_A: begin
          mul_q   <= mac_res[33:0];
          state_q <= ST_CHS_B;
        end
        ST_CHS_B: begin
          lba_q   <= mac_res[31:0];
          state_q <= ST_XFER;
        end
        ST_DIV_A: begin
          quot_q  <= mac_res[47:24];
          state_q <= ST_DIV_B;
        end
        ST_DIV_B: begin
          mul_q   <= mac_res[33:0];
          state_q <= ST_DIV_C;
        end
        ST_DIV_C: begin
          // estimate is low by at most one
          lba_q   <= {8'b0, quot_q} + {31'b0, (div_rem >= SB_REM)};
          state_q <= ST_XFER;
        end
        ST_XFER: begin
          xfer_q  <= mac_res[25:0];
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the result register is free
          if (out_free) begin
            out_rsp_q   <= done_rsp;
            out_valid_q <= 1'b1;
            if (push) begin
              ring_idx_q   <= idx_next;
              push_total_q <= push_total_q + 8'd1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;
  assign cfg_ready_o = 1'b1;

endmodule

@@ hdl/scfd_mac.sv @@
// ----------------------------------------------------------------------------
// scfd_mac
// Shared multiply-add unit of the decoder sequencer: res = a * b + c.
// ----------------------------------------------------------------------------
module scfd_mac (
  input  scfd_pkg::scfd_mac_op_t             op_i,
  output logic [scfd_pkg::MAC_RES_W-1:0]     res_o
);
  import scfd_pkg::*;

  assign res_o = MAC_RES_W'(op_i.a) * MAC_RES_W'(op_i.b) + MAC_RES_W'(op_i.c);

endmodule

@@ hdl/scfd_checker.sv @@
// ----------------------------------------------------------------------------
// scfd_checker
// Port-level checks for the SATA command FIS decoder.
// ----------------------------------------------------------------------------
module scfd_port_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_o,
  input  scfd_pkg::scfd_req_t               in_req_i,
  input  logic                              out_valid_o,
  input  logic                              out_ready_i,
  input  scfd_pkg::scfd_rsp_t               out_rsp_o,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_o,
  input  logic [scfd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]                       cfg_data_i
);
  import scfd_pkg::*;

  // one request at a time: busy right after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("decoder took a request while busy");

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // ring entries come only from fast read or write actions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.entry_pushed |->
      (out_rsp_o.action == ACT_DMA_WRITE || out_rsp_o.action == ACT_PIO_WRITE ||
       out_rsp_o.action == ACT_DMA_READ  || out_rsp_o.action == ACT_PIO_READ))
    else $error("entry pushed for a non-transfer action");

  // no entry, no entry fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.entry_pushed |->
      out_rsp_o.entry_slot == '0 && out_rsp_o.entry_address == '0 &&
      out_rsp_o.entry_type_word == '0 && out_rsp_o.entry_file == '0)
    else $error("entry fields set without a push");

  // error and slow-path results carry no transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.action == ACT_ID_NOT_FOUND || out_rsp_o.action == ACT_SLOW) |->
      out_rsp_o.transfer_bytes == '0 && !out_rsp_o.action_deferred)
    else $error("transfer fields set on a non-transfer action");

endmodule

bind sata_command_fis_decoder_core scfd_port_checker u_scfd_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_index_i (cfg_index_i),
  .cfg_data_i  (cfg_data_i)
);

@@ verif/scfd_checker.sv @@
// ----------------------------------------------------------------------------
// scfd_checker
// Watches the request, response and register channels of the command FIS
// decoder, predicts each response from its own copy of the registers and
// ring state, and compares every taken response field by field.
// ----------------------------------------------------------------------------
module scfd_checker #(
  parameter int RING_DEPTH   = 64,
  parameter int SECTOR_BYTES = 512
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  scfd_pkg::scfd_req_t            in_req_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  scfd_pkg::scfd_rsp_t            out_rsp_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [scfd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  output int                             mismatches_o,
  output int                             pending_o,
  output int                             results_o,
  output int                             drops_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import scfd_pkg::*;

  logic [7:0]  spw_low, spw_high, spr_low, spr_high;
  logic [31:0] last_lba;
  logic [4:0]  chs_heads;
  logic [7:0]  chs_sectors;
  int unsigned ring_wr_idx;
  logic [7:0]  push_total;

  scfd_rsp_t expected_rsp_q[$];
  int in_total, out_total;
  int mismatch_total = 0;
  int checked_total  = 0;
  int drop_total     = 0;

  assign mismatches_o = mismatch_total;
  assign pending_o    = in_total - out_total;
  assign results_o    = checked_total;
  assign drops_o      = drop_total;

  // Work out the response to one command and advance the ring state.
  function automatic scfd_rsp_t decode_command(scfd_req_t r);
    scfd_rsp_t   e;
    logic        sp_wr, sp_rd, special, dir;
    logic [63:0] offset, byte_total;
    logic [31:0] lba, cyl, head, sec;
    logic [16:0] count;
    logic [33:0] span, limit;
    e     = '0;
    lba   = '0;
    count = '0;
    sp_wr   = (r.command_code > spw_low) && (r.command_code < spw_high);
    sp_rd   = (r.command_code > spr_low) && (r.command_code < spr_high);
    special = sp_wr || sp_rd;
    offset  = 64'(r.fis_word1[23:0]) * 64'd512;

    if (r.class_lba28) begin
      if (!r.fis_word1[30]) begin
        cyl  = 32'(r.fis_word1[23:8]);
        head = 32'(r.fis_word1[27:24]);
        sec  = 32'(r.fis_word1[7:0]);
        // sector zero wraps through the 32-bit subtract
        lba  = (cyl * 32'(chs_heads) + head) * 32'(chs_sectors) + sec - 32'd1;
      end else begin
        lba = r.fis_word1 & 32'h0FFF_FFFF;
      end
      count = 17'(r.fis_word3_low[7:0]);
      if (count == '0 && !r.class_no_count) count = CNT28_DEFAULT;
    end else if (r.class_lba48) begin
      lba   = {r.fis_word2_low, r.fis_word1[23:0]};
      count = 17'(r.fis_word3_low);
      if (count == '0 && !r.class_no_count) count = CNT48_DEFAULT;
    end

    if (special) lba = 32'(offset / 64'(SECTOR_BYTES));

    span  = 34'(lba) + 34'(count);
    limit = 34'(last_lba) + 34'd1;
    e.block_address = lba;
    e.block_count   = count;

    if (!r.class_no_count && span > limit) begin
      e.action = ACT_ID_NOT_FOUND;
    end else if (r.class_host_to_device || r.class_device_to_host) begin
      // write wins when both direction bits are set
      dir = r.class_host_to_device;
      if (dir) begin
        e.action = (r.command_code == OP_WRITE_DMA || r.command_code == OP_WRITE_DMA_EXT
                    || sp_wr) ? ACT_DMA_WRITE : ACT_PIO_WRITE;
      end else begin
        e.action = (r.command_code == OP_READ_DMA || r.command_code == OP_READ_DMA_EXT
                    || sp_rd) ? ACT_DMA_READ : ACT_PIO_READ;
      end
      if ((ring_wr_idx + 1) % RING_DEPTH != int'(r.consumer_front)) begin
        e.entry_pushed = 1'b1;
        e.entry_slot   = 6'(ring_wr_idx);
        if (special) begin
          e.entry_address   = offset[31:0];
          e.entry_type_word = {7'd0, dir, offset[47:32], r.command_code};
          e.entry_file      = r.file_id;
        end else begin
          e.entry_address   = lba;
          e.entry_type_word = {31'd0, dir};
        end
        ring_wr_idx = (ring_wr_idx + 1) % RING_DEPTH;
        push_total  = push_total + 8'd1;
      end else begin
        drop_total++;
      end
      byte_total        = 64'(count) * 64'(SECTOR_BYTES);
      e.transfer_bytes  = byte_total[25:0];
      e.action_deferred = r.hw_queue_full;
    end else begin
      e.action = ACT_SLOW;
    end
    e.pushed_count_low = push_total;
    return e;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_total++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    scfd_rsp_t want, got;
    if (!rst_ni) begin
      spw_low     = '0;
      spw_high    = '0;
      spr_low     = '0;
      spr_high    = '0;
      last_lba    = '0;
      chs_heads   = CHS_HEADS_RST;
      chs_sectors = CHS_SECTORS_RST;
      ring_wr_idx = 0;
      push_total  = '0;
      expected_rsp_q.delete();
      in_total  <= 0;
      out_total <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (scfd_cfg_e'(cfg_index_i))
          CFG_SPW_LOW:     spw_low     = cfg_data_i[7:0];
          CFG_SPW_HIGH:    spw_high    = cfg_data_i[7:0];
          CFG_SPR_LOW:     spr_low     = cfg_data_i[7:0];
          CFG_SPR_HIGH:    spr_high    = cfg_data_i[7:0];
          CFG_LAST_LBA:    last_lba    = cfg_data_i;
          CFG_CHS_HEADS:   chs_heads   = cfg_data_i[4:0];
          CFG_CHS_SECTORS: chs_sectors = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_rsp_q.push_back(decode_command(in_req_i));
        in_total <= in_total + 1;
      end
      if (out_valid_i && out_ready_i) begin
        out_total <= out_total + 1;
        got = out_rsp_i;
        if (expected_rsp_q.size() == 0) begin
          mismatch_total++;
          $display("%0t: response with no command outstanding, expected none, got 0x%0h",
                   $time, got);
        end else begin
          want = expected_rsp_q.pop_front();
          checked_total++;
          check_field("action",           32'(want.action),           32'(got.action));
          check_field("action_deferred",  32'(want.action_deferred),  32'(got.action_deferred));
          check_field("block_address",    want.block_address,         got.block_address);
          check_field("block_count",      32'(want.block_count),      32'(got.block_count));
          check_field("transfer_bytes",   32'(want.transfer_bytes),   32'(got.transfer_bytes));
          check_field("entry_pushed",     32'(want.entry_pushed),     32'(got.entry_pushed));
          check_field("entry_slot",       32'(want.entry_slot),       32'(got.entry_slot));
          check_field("entry_address",    want.entry_address,         got.entry_address);
          check_field("entry_type_word",  want.entry_type_word,       got.entry_type_word);
          check_field("entry_file",       want.entry_file,            got.entry_file);
          check_field("pushed_count_low", 32'(want.pushed_count_low), 32'(got.pushed_count_low));
        end
      end
    end
  end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives command requests and register writes into the command FIS decoder
// under several register settings and idle mixes; a checker beside the block
// predicts and compares every response, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import scfd_pkg::*;

  localparam int CLK_HALF        = 10;
  localparam int RESET_CYCLES    = 11;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 230;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_CYCLES = 5000;
  localparam int SETTLE_CYCLES   = 10;

  // class bit order: lba28, lba48, no_count, host_to_device, device_to_host
  localparam logic [4:0] CLS_28 = 5'b10000;
  localparam logic [4:0] CLS_48 = 5'b01000;
  localparam logic [4:0] CLS_NC = 5'b00100;
  localparam logic [4:0] CLS_WR = 5'b00010;
  localparam logic [4:0] CLS_RD = 5'b00001;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  scfd_req_t            in_req    = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  scfd_rsp_t            out_rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;

  int mismatches, pending, results, drops;

  // register values as last written, used to aim the stimulus
  logic [7:0]  cfg_spw_low, cfg_spw_high, cfg_spr_low, cfg_spr_high;
  logic [31:0] cfg_last_lba;

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  hold_request   = 1'b0;
  bit  front_stuck    = 1'b0;
  logic [5:0] front_hold = '0;
  int  sent_total     = 0;
  int  stalled_cycles = 0;

  always #CLK_HALF clk_i = ~clk_i;

  sata_command_fis_decoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  scfd_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_rsp_i    (out_rsp),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .results_o    (results),
    .drops_o      (drops)
  );

  function automatic scfd_req_t make_cmd(logic [7:0] op, logic [31:0] w1, logic [7:0] w2,
                                         logic [15:0] w3, logic [31:0] fid, logic [4:0] cls,
                                         logic [5:0] front, logic hwfull);
    scfd_req_t r;
    r.command_code   = op;
    r.fis_word1      = w1;
    r.fis_word2_low  = w2;
    r.fis_word3_low  = w3;
    r.file_id        = fid;
    {r.class_lba28, r.class_lba48, r.class_no_count,
     r.class_host_to_device, r.class_device_to_host} = cls;
    r.consumer_front = front;
    r.hw_queue_full  = hwfull;
    return r;
  endfunction

  // opcode strictly inside (lo, hi), or any opcode when the range is empty
  function automatic logic [7:0] pick_between(logic [7:0] lo, logic [7:0] hi);
    if (int'(hi) > int'(lo) + 1) return 8'($urandom_range(int'(lo) + 1, int'(hi) - 1));
    return 8'($urandom);
  endfunction

  function automatic scfd_req_t random_cmd();
    scfd_req_t   r;
    int          sel;
    logic [16:0] eff;
    logic [33:0] target;
    r.fis_word1     = $urandom;
    r.fis_word2_low = 8'($urandom);
    r.fis_word3_low = 16'($urandom);
    r.file_id       = $urandom;
    case ($urandom_range(0, 9))
      0: r.fis_word3_low = '0;
      1: r.fis_word3_low[7:0] = '0;
      2: r.fis_word3_low = 16'($urandom_range(1, 16));
      default: ;
    endcase
    if ($urandom_range(0, 19) == 0) r.fis_word1[7:0] = '0;

    sel = $urandom_range(0, 9);
    {r.class_lba28, r.class_lba48} = (sel < 4) ? 2'b10 : (sel < 8) ? 2'b01 :
                                     (sel == 8) ? 2'b11 : 2'b00;
    r.class_no_count = ($urandom_range(0, 7) == 0);
    sel = $urandom_range(0, 9);
    {r.class_host_to_device, r.class_device_to_host} = (sel < 4) ? 2'b10 : (sel < 8) ? 2'b01 :
                                                       (sel == 8) ? 2'b11 : 2'b00;

    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0: r.command_code = OP_READ_DMA;
          1: r.command_code = OP_READ_DMA_EXT;
          2: r.command_code = OP_WRITE_DMA;
          default: r.command_code = OP_WRITE_DMA_EXT;
        endcase
      end
      1: r.command_code = pick_between(cfg_spw_low, cfg_spw_high);
      2: r.command_code = pick_between(cfg_spr_low, cfg_spr_high);
      default: r.command_code = 8'($urandom);
    endcase

    // aim 48-bit commands at the drive limit
    if (r.class_lba48 && !r.class_lba28 && $urandom_range(0, 2) == 0) begin
      eff = (r.fis_word3_low != '0) ? 17'(r.fis_word3_low) :
            (r.class_no_count ? 17'd0 : CNT48_DEFAULT);
      target = 34'(cfg_last_lba) + 34'd1 - 34'(eff) + 34'($urandom_range(0, 2)) - 34'd1;
      r.fis_word1[23:0] = target[23:0];
      r.fis_word2_low   = target[31:24];
    end

    // the consumer mostly sits still, so the ring fills now and then
    if (!front_stuck && $urandom_range(0, 39) == 0) front_hold = 6'($urandom);
    r.consumer_front = (front_stuck || $urandom_range(0, 9) < 7) ? front_hold : 6'($urandom);
    r.hw_queue_full  = ($urandom_range(0, 3) == 0);
    return r;
  endfunction

  task automatic send_command(scfd_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk_i); while (!in_ready);
    sent_total++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending > 0);
  endtask

  task automatic write_reg(scfd_cfg_e idx, logic [31:0] value);
    case (idx)
      CFG_SPW_LOW:   cfg_spw_low  = value[7:0];
      CFG_SPW_HIGH:  cfg_spw_high = value[7:0];
      CFG_SPR_LOW:   cfg_spr_low  = value[7:0];
      CFG_SPR_HIGH:  cfg_spr_high = value[7:0];
      CFG_LAST_LBA:  cfg_last_lba = value;
      default: ;
    endcase
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    // upper bits beyond the register width are noise
    if (idx == CFG_LAST_LBA)       cfg_data <= value;
    else if (idx == CFG_CHS_HEADS) cfg_data <= {27'($urandom), value[4:0]};
    else                           cfg_data <= {24'($urandom), value[7:0]};
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_registers(logic [7:0] swl, logic [7:0] swh, logic [7:0] srl,
                               logic [7:0] srh, logic [31:0] last, logic [4:0] heads,
                               logic [7:0] sectors);
    write_reg(CFG_SPW_LOW, 32'(swl));
    write_reg(CFG_SPW_HIGH, 32'(swh));
    write_reg(CFG_SPR_LOW, 32'(srl));
    write_reg(CFG_SPR_HIGH, 32'(srh));
    write_reg(CFG_LAST_LBA, last);
    write_reg(CFG_CHS_HEADS, 32'(heads));
    write_reg(CFG_CHS_SECTORS, 32'(sectors));
  endtask

  // response side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stalled_cycles = 0;
    else
      stalled_cycles++;
    if (stalled_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog: no request moved for %0d cycles", stalled_cycles);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    logic [7:0] lo_w, lo_r;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: overlapping special ranges, full drive
    set_registers(8'h40, 8'h80, 8'h60, 8'hA0, 32'hFFFF_FFFF, 5'd16, 8'd63);
    // first push after reset with the consumer one ahead: ring full, entry dropped
    send_command(make_cmd(OP_READ_DMA, 32'h4000_1234, 8'h00, 16'h0008, 32'h0,
                          CLS_28 | CLS_RD, 6'd1, 1'b0));
    send_command(make_cmd(OP_WRITE_DMA, 32'h4FFF_FFFF, 8'hAB, 16'h0000, 32'h0,
                          CLS_28 | CLS_WR, 6'd0, 1'b0));
    send_command(make_cmd(OP_READ_DMA_EXT, 32'h00FF_FFFF, 8'hFF, 16'h0000, 32'h0,
                          CLS_48 | CLS_RD, 6'd0, 1'b1));
    send_command(make_cmd(OP_WRITE_DMA_EXT, 32'h0000_0010, 8'h00, 16'hFFFF, 32'h0,
                          CLS_48 | CLS_WR, 6'd0, 1'b1));
    send_command(make_cmd(8'h20, 32'h4000_0100, 8'h00, 16'h0101, 32'h0,
                          CLS_28 | CLS_RD, 6'd0, 1'b0));
    send_command(make_cmd(8'h30, 32'h4000_0200, 8'h00, 16'h0004, 32'h0,
                          CLS_28 | CLS_WR, 6'd0, 1'b0));
    // CHS translation, then sector zero at and just past the limit
    send_command(make_cmd(OP_READ_DMA, 32'h0512_3401, 8'h00, 16'h0002, 32'h0,
                          CLS_28 | CLS_RD, 6'd0, 1'b0));
    send_command(make_cmd(OP_READ_DMA, 32'h0000_0000, 8'h00, 16'h0001, 32'h0,
                          CLS_28 | CLS_RD, 6'd0, 1'b0));
    send_command(make_cmd(OP_READ_DMA, 32'h0000_0000, 8'h00, 16'h0002, 32'h0,
                          CLS_28 | CLS_RD, 6'd0, 1'b0));
    send_command(make_cmd(8'hEC, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF,
                          CLS_WR, 6'd0, 1'b0));
    send_command(make_cmd(OP_READ_DMA, 32'h4000_0055, 8'h12, 16'h0003, 32'h0,
                          CLS_28 | CLS_48 | CLS_RD, 6'd0, 1'b0));
    send_command(make_cmd(8'h30, 32'h0000_0400, 8'h00, 16'h0010, 32'h0,
                          CLS_48 | CLS_WR | CLS_RD, 6'd0, 1'b0));
    send_command(make_cmd(8'hEF, 32'h4000_0000, 8'h00, 16'h0001, 32'h0,
                          CLS_28, 6'd0, 1'b0));
    send_command(make_cmd(8'hEF, 32'h4000_0000, 8'h00, 16'h0001, 32'h0,
                          CLS_28, 6'd0, 1'b1));
    send_command(make_cmd(8'hE0, 32'h4000_0001, 8'h00, 16'h0000, 32'h0,
                          CLS_28 | CLS_NC | CLS_RD, 6'd0, 1'b0));
    send_command(make_cmd(8'hE0, 32'hFFFF_FFFF, 8'hFF, 16'h0000, 32'h0,
                          CLS_48 | CLS_NC | CLS_WR, 6'd0, 1'b0));
    // special opcodes: write range only, read range only, both, bounds
    send_command(make_cmd(8'h50, 32'h00FF_FFFF, 8'h00, 16'h0001, 32'hDEAD_BEEF,
                          CLS_48 | CLS_WR, 6'd0, 1'b0));
    send_command(make_cmd(8'h90, 32'h0000_0001, 8'h00, 16'h0001, 32'h1234_5678,
                          CLS_28 | CLS_RD, 6'd0, 1'b0));
    send_command(make_cmd(8'h70, 32'h0080_0000, 8'h00, 16'h0001, 32'hFFFF_FFFF,
                          CLS_48 | CLS_WR, 6'd0, 1'b0));
    send_command(make_cmd(8'h70, 32'h0000_1000, 8'h00, 16'h0001, 32'h0000_0001,
                          CLS_48 | CLS_RD, 6'd0, 1'b0));
    send_command(make_cmd(8'h50, 32'h0000_2000, 8'h00, 16'h0001, 32'h5A5A_5A5A,
                          CLS_48 | CLS_RD, 6'd0, 1'b0));
    send_command(make_cmd(8'h40, 32'h0000_0020, 8'h00, 16'h0001, 32'h0,
                          CLS_48 | CLS_WR, 6'd0, 1'b0));
    send_command(make_cmd(8'h80, 32'h0000_0020, 8'h00, 16'h0001, 32'h0,
                          CLS_48 | CLS_WR, 6'd0, 1'b0));

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      lo_w = 8'($urandom_range(0, 200));
      lo_r = 8'($urandom_range(0, 200));
      case (ph)
        0: set_registers(8'h10, 8'h30, 8'h28, 8'h48, 32'hFFFF_FFFF, 5'd16, 8'd63);
        1: set_registers(8'h00, 8'hFF, 8'hFF, 8'h00, 32'hFFFF_FFFF, 5'd0, 8'd0);
        2: set_registers(8'hFF, 8'hFF, 8'h00, 8'hFF, 32'h0000_0000, 5'd16, 8'd255);
        4: set_registers(8'h80, 8'hC0, 8'hA0, 8'hE0, 32'($urandom_range(0, 32'h000F_FFFF)),
                         5'd31, 8'd1);
        default: set_registers(lo_w, lo_w + 8'($urandom_range(0, 55)), lo_r,
                               lo_r + 8'($urandom_range(0, 55)), $urandom,
                               5'($urandom), 8'($urandom));
      endcase
      // stuck consumer: the ring fills and stays full
      front_stuck = (ph == 4);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (ph == 3 && i == 60) hold_request = 1'b1;
        send_command(random_cmd());
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Summary: %0d commands over 7 register settings, four idle mixes and one long",
             sent_total);
    $display("  response hold-off; %0d responses compared, %0d commands met a full ring.",
             results, drops);
    if (mismatches == 0 && pending == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
hdl/scfd_pkg.sv
hdl/scfd_mac.sv
hdl/sata_command_fis_decoder_core.sv
hdl/scfd_checker.sv
verif/scfd_checker.sv
verif/tb_top.sv
